### rtl/cylinder_surface_evaluator_top_macros.svh
// Assertion macros shared by the cylinder surface evaluator RTL.
// No dependencies.
`ifndef CYLINDER_SURFACE_EVALUATOR_TOP_MACROS_SVH
`define CYLINDER_SURFACE_EVALUATOR_TOP_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define CSE_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence on the next edge.
`define CSE_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/cse_pkg.sv
// Package for the cylinder surface evaluator: widths, action codes, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
package cse_pkg;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 16;

    localparam logic [2:0] ACT_POINT  = 3'd0;
    localparam logic [2:0] ACT_DU     = 3'd1;
    localparam logic [2:0] ACT_DV     = 3'd2;
    localparam logic [2:0] ACT_DUU    = 3'd3;
    localparam logic [2:0] ACT_DUV    = 3'd4;
    localparam logic [2:0] ACT_DVV    = 3'd5;
    localparam logic [2:0] ACT_NORMAL = 3'd6;

    localparam logic [1:0] REG_ORIGIN = 2'd0;
    localparam logic [1:0] REG_XDIR   = 2'd1;
    localparam logic [1:0] REG_YDIR   = 2'd2;
    localparam logic [1:0] REG_RADIUS = 2'd3;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [23:0] comp_t;

    function automatic logic signed [33:0] cordic_atan(input logic [3:0] i);
        logic signed [33:0] a;
        begin
            case (i)
                4'd0:    a = 34'sh20000000;
                4'd1:    a = 34'sh12E4051E;
                4'd2:    a = 34'sh09FB385B;
                4'd3:    a = 34'sh051111D4;
                4'd4:    a = 34'sh028B0D43;
                4'd5:    a = 34'sh0145D7E1;
                4'd6:    a = 34'sh00A2F61E;
                4'd7:    a = 34'sh00517C55;
                4'd8:    a = 34'sh0028BE53;
                4'd9:    a = 34'sh00145F2F;
                4'd10:   a = 34'sh000A2F98;
                4'd11:   a = 34'sh000517CC;
                4'd12:   a = 34'sh00028BE6;
                4'd13:   a = 34'sh000145F3;
                4'd14:   a = 34'sh0000A2FA;
                default: a = 34'sh0000517D;
            endcase
            return a;
        end
    endfunction

    // Round half up by 2^sh and saturate to 24 bits.
    function automatic logic [24:0] round_sat(input logic signed [71:0] v,
                                              input int sh);
        logic signed [71:0] q;
        logic [24:0] r;
        begin
            q = (v + (72'sd1 <<< (sh - 1))) >>> sh;
            if (q > 72'sd8388607)
                r = {1'b1, 24'h7FFFFF};
            else if (q < -72'sd8388608)
                r = {1'b1, 24'h800000};
            else
                r = {1'b0, q[23:0]};
            return r;
        end
    endfunction
endpackage

### rtl/cse_if.sv
// Valid/ready channel interfaces for the cylinder surface evaluator.
// No dependencies.
`timescale 1ns / 1ps
interface cse_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [15:0]       u_angle;
    logic signed [19:0] v_height;
    modport source (output valid, action, u_angle, v_height, input ready);
    modport sink   (input valid, action, u_angle, v_height, output ready);
endinterface

interface cse_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic               saturated;
    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

interface cse_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/cylinder_surface_evaluator_top.sv
// Cylinder surface evaluator top level: CORDIC pipeline, product and round stages.
// Depends on cse_pkg, cse_if and the assertion macro header.
`timescale 1ns / 1ps
`include "cylinder_surface_evaluator_top_macros.svh"
// One query per clock when not stalled, through these stages: one stage for
// the axis cross product, sixteen CORDIC stages (one micro-rotation each), a
// quadrant and Q.16 round stage, a product stage and a sum/round/saturate stage
// that feeds the output register. A stall holds every stage; the whole pipe
// moves only when the output register is free or being taken.
module cylinder_surface_evaluator_top #(
    parameter int ANGLE_BITS = cse_pkg::ANGLE_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    cse_cfg_if.sink cfg,
    cse_in_if.sink  in_ch,
    cse_out_if.source out_ch
);
    import cse_pkg::*;

    localparam int NS = CORDIC_STEPS;

    logic [59:0] origin_reg;
    logic [47:0] xdir_reg;
    logic [47:0] ydir_reg;
    logic [19:0] radius_reg;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            xdir_reg   <= 48'd16384;
            ydir_reg   <= 48'd1073741824;
            radius_reg <= 20'd1024;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ORIGIN: origin_reg <= cfg.data[59:0];
                REG_XDIR:   xdir_reg   <= cfg.data[47:0];
                REG_YDIR:   ydir_reg   <= cfg.data[47:0];
                REG_RADIUS: radius_reg <= cfg.data[19:0];
                default:    origin_reg <= origin_reg;
            endcase
        end
    end

    logic adv;
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // Direction components.
    logic signed [15:0] xd [3];
    logic signed [15:0] yd [3];
    logic signed [19:0] od [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            xd[k] = xdir_reg[16*k +: 16];
            yd[k] = ydir_reg[16*k +: 16];
            od[k] = origin_reg[20*k +: 20];
        end
    end

    // Stage 0: latch input, axis cross product, start CORDIC.
    logic               v0_reg;
    logic [2:0]         act0_reg;
    logic signed [19:0] vh0_reg;
    logic [1:0]         q0_reg;
    logic signed [33:0] ax0_reg [3];
    logic [31:0]        turn;
    // Bits of the angle above ANGLE_BITS fall off the top of the turn word.
    assign turn = {16'h0000, in_ch.u_angle} << (32 - ANGLE_BITS);

    // CORDIC pipeline arrays: index i holds values before step i.
    logic signed [33:0] cx_reg [NS+1];
    logic signed [33:0] cy_reg [NS+1];
    logic signed [33:0] cz_reg [NS+1];
    logic               cv_reg [NS+1];
    logic [2:0]         cact_reg [NS+1];
    logic signed [19:0] cvh_reg [NS+1];
    logic [1:0]         cq_reg [NS+1];
    logic signed [33:0] cax_reg [NS+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act0_reg <= in_ch.action;
            vh0_reg  <= in_ch.v_height;
            q0_reg   <= turn[31:30];
            ax0_reg[0] <= 34'(xd[1] * yd[2]) - 34'(xd[2] * yd[1]);
            ax0_reg[1] <= 34'(xd[2] * yd[0]) - 34'(xd[0] * yd[2]);
            ax0_reg[2] <= 34'(xd[0] * yd[1]) - 34'(xd[1] * yd[0]);
            cx_reg[0] <= CORDIC_X0;
            cy_reg[0] <= '0;
            cz_reg[0] <= 34'($signed({2'b00, turn[29:0]}));
        end
    end

    always_comb
    begin
        cv_reg[0]   = v0_reg;
        cact_reg[0] = act0_reg;
        cvh_reg[0]  = vh0_reg;
        cq_reg[0]   = q0_reg;
        for (int k = 0; k < 3; k++)
            cax_reg[0][k] = ax0_reg[k];
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (adv)
                cv_reg[i+1] <= cv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!cz_reg[i][33])
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - cordic_atan(4'(i));
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + cordic_atan(4'(i));
                end
                cact_reg[i+1] <= cact_reg[i];
                cvh_reg[i+1]  <= cvh_reg[i];
                cq_reg[i+1]   <= cq_reg[i];
                for (int k = 0; k < 3; k++)
                    cax_reg[i+1][k] <= cax_reg[i][k];
            end
        end
    end

    // Quadrant stage: round to Q.16 and rotate.
    logic signed [19:0] xr, yr;
    assign xr = 20'((cx_reg[NS] + 34'sd8192) >>> 14);
    assign yr = 20'((cy_reg[NS] + 34'sd8192) >>> 14);

    logic               v1_reg;
    logic [2:0]         act1_reg;
    logic signed [19:0] vh1_reg;
    logic signed [33:0] ax1_reg [3];
    logic signed [19:0] c1_reg, s1_reg;
    logic signed [35:0] rx1_reg [3];
    logic signed [35:0] ry1_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= cv_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act1_reg <= cact_reg[NS];
            vh1_reg  <= cvh_reg[NS];
            for (int k = 0; k < 3; k++)
            begin
                ax1_reg[k] <= cax_reg[NS][k];
                rx1_reg[k] <= 36'($signed({1'b0, radius_reg}) * 37'(xd[k]));
                ry1_reg[k] <= 36'($signed({1'b0, radius_reg}) * 37'(yd[k]));
            end
            case (cq_reg[NS])
                2'd0:    begin c1_reg <= xr;  s1_reg <= yr;  end
                2'd1:    begin c1_reg <= -yr; s1_reg <= xr;  end
                2'd2:    begin c1_reg <= -xr; s1_reg <= -yr; end
                default: begin c1_reg <= yr;  s1_reg <= -xr; end
            endcase
        end
    end

    // Product stage.
    logic               v2_reg;
    logic [2:0]         act2_reg;
    logic signed [33:0] ax2_reg [3];
    logic signed [57:0] crx2_reg [3];
    logic signed [57:0] sry2_reg [3];
    logic signed [57:0] srx2_reg [3];
    logic signed [57:0] cry2_reg [3];
    logic signed [37:0] cxd2_reg [3];
    logic signed [37:0] syd2_reg [3];
    logic signed [55:0] vax2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act2_reg <= act1_reg;
            for (int k = 0; k < 3; k++)
            begin
                ax2_reg[k]  <= ax1_reg[k];
                crx2_reg[k] <= 58'(c1_reg) * 58'(rx1_reg[k]);
                sry2_reg[k] <= 58'(s1_reg) * 58'(ry1_reg[k]);
                srx2_reg[k] <= 58'(s1_reg) * 58'(rx1_reg[k]);
                cry2_reg[k] <= 58'(c1_reg) * 58'(ry1_reg[k]);
                cxd2_reg[k] <= 38'(c1_reg) * 38'(xd[k]);
                syd2_reg[k] <= 38'(s1_reg) * 38'(yd[k]);
                vax2_reg[k] <= 56'(vh1_reg) * 56'(ax1_reg[k]);
            end
        end
    end

    // Sum, round, saturate into the output register.
    logic [24:0] rs [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (act2_reg)
                ACT_POINT:  rs[k] = round_sat((72'(od[k]) <<< 30) + 72'(crx2_reg[k])
                                + 72'(sry2_reg[k]) + (72'(vax2_reg[k]) <<< 2), 30);
                ACT_DU:     rs[k] = round_sat(72'(cry2_reg[k]) - 72'(srx2_reg[k]), 30);
                ACT_DV:     rs[k] = round_sat(72'(ax2_reg[k]), 18);
                ACT_DUU:    rs[k] = round_sat(-(72'(crx2_reg[k]) + 72'(sry2_reg[k])), 30);
                ACT_NORMAL: rs[k] = round_sat(72'(cxd2_reg[k]) + 72'(syd2_reg[k]), 20);
                default:    rs[k] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.valid <= 1'b0;
        else if (adv)
            out_ch.valid <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ch.out_x     <= rs[0][23:0];
            out_ch.out_y     <= rs[1][23:0];
            out_ch.out_z     <= rs[2][23:0];
            out_ch.saturated <= rs[0][24] | rs[1][24] | rs[2][24];
        end
    end

    `CSE_ASSERT_NEXT(a_hold_out, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `CSE_ASSERT_IMP(a_ready_free, clk, rst_n, !out_ch.valid, in_ch.ready)
    `CSE_ASSERT_NEXT(a_stage_move, clk, rst_n, adv && v2_reg, out_ch.valid)
    `CSE_ASSERT_NEXT(a_no_invent, clk, rst_n, adv && !v2_reg, !out_ch.valid)
endmodule

### dv/cylinder_surface_evaluator_top_tb.sv
// Self-checking testbench for cylinder_surface_evaluator_top: a queue-fed driver,
// a config writer and a scoreboard monitor checked against an in-bench predictor.
// Depends on cse_pkg, cse_if and the RTL top level.
`timescale 1ns / 1ps
module cylinder_surface_evaluator_top_tb;
    import cse_pkg::*;

    typedef struct {
        logic [2:0]         action;
        logic [15:0]        u_angle;
        logic signed [19:0] v_height;
    } query_t;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               sat;
    } vec_t;

    typedef struct {
        logic [1:0]  index;
        logic [63:0] data;
    } reg_wr_t;

    localparam longint ATAN_TURN [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    localparam int DRAIN_CYCLES = 30;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;

    cse_cfg_if cfg_ch();
    cse_in_if  in_ch();
    cse_out_if out_ch();

    cylinder_surface_evaluator_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow copy of the geometry registers
    logic [59:0] origin_reg;
    logic [47:0] xdir_reg;
    logic [47:0] ydir_reg;
    logic [19:0] radius_reg;

    query_t  query_q[$];
    reg_wr_t reg_wr_q[$];
    vec_t    expected_vec_q[$];
    int      mismatches;
    bit      calm;
    longint  cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint round_clip(input longint v, input int sh, inout bit sat);
        longint q;
        q = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (q > 64'sd8388607)
        begin
            sat = 1'b1;
            q = 64'sd8388607;
        end
        else if (q < -64'sd8388608)
        begin
            sat = 1'b1;
            q = -64'sd8388608;
        end
        return q;
    endfunction

    function automatic vec_t eval_surface(input query_t qy);
        longint x, y, z, dx, dy, c, s, r, v, rx, ry, acc;
        longint o[3], xd[3], yd[3], ax[3], res[3];
        logic [31:0] turn;
        bit sat;
        vec_t e;
        turn = {16'h0000, qy.u_angle} << (32 - ANGLE_BITS_DEF);
        z = longint'(turn[29:0]);
        x = 652032874;
        y = 0;
        sat = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i];
            end
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        case (turn[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        for (int k = 0; k < 3; k++)
        begin
            o[k]  = longint'($signed(origin_reg[20*k +: 20]));
            xd[k] = longint'($signed(xdir_reg[16*k +: 16]));
            yd[k] = longint'($signed(ydir_reg[16*k +: 16]));
        end
        ax[0] = xd[1] * yd[2] - xd[2] * yd[1];
        ax[1] = xd[2] * yd[0] - xd[0] * yd[2];
        ax[2] = xd[0] * yd[1] - xd[1] * yd[0];
        r = longint'(radius_reg);
        v = longint'(qy.v_height);
        for (int k = 0; k < 3; k++)
        begin
            rx = r * xd[k];
            ry = r * yd[k];
            case (qy.action)
                ACT_POINT:
                begin
                    acc = (o[k] <<< 30) + c * rx + s * ry + v * ax[k] * 4;
                    res[k] = round_clip(acc, 30, sat);
                end
                ACT_DU:     res[k] = round_clip(-s * rx + c * ry, 30, sat);
                ACT_DV:     res[k] = round_clip(ax[k], 18, sat);
                ACT_DUU:    res[k] = round_clip(-(c * rx + s * ry), 30, sat);
                ACT_NORMAL: res[k] = round_clip(c * xd[k] + s * yd[k], 20, sat);
                default:    res[k] = 0;
            endcase
        end
        e.x = res[0][23:0];
        e.y = res[1][23:0];
        e.z = res[2][23:0];
        e.sat = sat;
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // config writer; shadow registers follow each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= REG_ORIGIN;
            cfg_ch.data  <= '0;
            origin_reg   <= '0;
            xdir_reg     <= 48'd16384;
            ydir_reg     <= 48'd1073741824;
            radius_reg   <= 20'd1024;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_ORIGIN: origin_reg <= cfg_ch.data[59:0];
                    REG_XDIR:   xdir_reg   <= cfg_ch.data[47:0];
                    REG_YDIR:   ydir_reg   <= cfg_ch.data[47:0];
                    default:    radius_reg <= cfg_ch.data[19:0];
                endcase
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (reg_wr_q.size() > 0)
                begin
                    reg_wr_t w;
                    w = reg_wr_q.pop_front();
                    cfg_ch.index <= w.index;
                    cfg_ch.data  <= w.data;
                    cfg_ch.valid <= 1'b1;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    // query driver; the expected vector is computed on each accepted beat
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.action   <= ACT_POINT;
            in_ch.u_angle  <= '0;
            in_ch.v_height <= '0;
            gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                query_t cur;
                cur.action   = in_ch.action;
                cur.u_angle  = in_ch.u_angle;
                cur.v_height = in_ch.v_height;
                expected_vec_q.push_back(eval_surface(cur));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap > 0)
                begin
                    gap = gap - 1;
                    in_ch.valid <= 1'b0;
                end
                // hold queries back until every pending register write has landed
                else if (query_q.size() > 0 && reg_wr_q.size() == 0 && !cfg_ch.valid)
                begin
                    query_t nx;
                    nx = query_q.pop_front();
                    in_ch.action   <= nx.action;
                    in_ch.u_angle  <= nx.u_angle;
                    in_ch.v_height <= nx.v_height;
                    in_ch.valid    <= 1'b1;
                    gap = pick_gap();
                    if ($urandom_range(0, 63) == 0)
                        calm = ~calm;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor with random backpressure
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                vec_t e;
                if (expected_vec_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat x=%0d y=%0d z=%0d sat=%0b",
                                 out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.saturated);
                end
                else
                begin
                    e = expected_vec_q.pop_front();
                    if (out_ch.out_x !== e.x || out_ch.out_y !== e.y ||
                        out_ch.out_z !== e.z || out_ch.saturated !== e.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp x=%0d y=%0d z=%0d sat=%0b, ",
                                      "got x=%0d y=%0d z=%0d sat=%0b"},
                                     e.x, e.y, e.z, e.sat, out_ch.out_x, out_ch.out_y,
                                     out_ch.out_z, out_ch.saturated);
                    end
                end
            end
            if (stall > 0)
            begin
                stall = stall - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                out_ch.ready <= (stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [47:0] pack_dir(input logic [15:0] x, input logic [15:0] y,
                                            input logic [15:0] z);
        return {z, y, x};
    endfunction

    task automatic add_query(input logic [2:0] a, input logic [15:0] u,
                             input logic signed [19:0] v);
        query_t qy;
        qy.action = a;
        qy.u_angle = u;
        qy.v_height = v;
        query_q.push_back(qy);
    endtask

    task automatic add_reg(input logic [1:0] idx, input logic [63:0] d);
        reg_wr_t w;
        w.index = idx;
        w.data = d;
        reg_wr_q.push_back(w);
    endtask

    task automatic run_random(input int n);
        logic signed [19:0] v;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       v = 20'sh80000;
                1:       v = 20'sh7FFFF;
                default: v = 20'($urandom);
            endcase
            add_query(3'($urandom_range(0, 7)), 16'($urandom), v);
        end
    endtask

    // hold until nothing is queued, in flight or expected, then let the pipe drain
    task automatic settle();
        wait (reg_wr_q.size() == 0 && !cfg_ch.valid && query_q.size() == 0 &&
              !in_ch.valid && expected_vec_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] u_dir [5] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
        rst_n = 1'b0;
        mismatches = 0;
        calm = 1'b0;
        cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: every action, quadrant boundaries, height extremes
        for (int a = 0; a < 8; a++)
            add_query(a[2:0], u_dir[a % 5], (a % 2) ? 20'sh7FFFF : 20'sh80000);
        for (int i = 0; i < 5; i++)
            add_query(ACT_POINT, u_dir[i], 20'sh00400);
        for (int i = 0; i < 5; i++)
            add_query(ACT_NORMAL, u_dir[i], 20'sh0);
        run_random(250);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    // tilted unit frame
                    add_reg(REG_ORIGIN, {4'h0, 20'sh00C00, 20'shFF000, 20'sh01234});
                    add_reg(REG_XDIR, pack_dir(16'h0000, 16'h0000, 16'h4000));
                    add_reg(REG_YDIR, pack_dir(16'h4000, 16'h0000, 16'h0000));
                    add_reg(REG_RADIUS, 64'd3072);
                end
                1:
                begin
                    // origin, radius and x direction at the positive extreme, y direction mixed: aims at saturation
                    add_reg(REG_ORIGIN, {4'h0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
                    add_reg(REG_XDIR, pack_dir(16'h7FFF, 16'h7FFF, 16'h7FFF));
                    add_reg(REG_YDIR, pack_dir(16'h8000, 16'h7FFF, 16'h8000));
                    add_reg(REG_RADIUS, 64'hFFFFF);
                end
                2:
                begin
                    add_reg(REG_ORIGIN, {4'h0, 20'h80000, 20'h80000, 20'h80000});
                    add_reg(REG_XDIR, pack_dir(16'h8000, 16'h8000, 16'h8000));
                    add_reg(REG_YDIR, pack_dir(16'h8000, 16'h8000, 16'h7FFF));
                    add_reg(REG_RADIUS, 64'd1);
                end
                3:
                begin
                    // zero radius drops every r term
                    add_reg(REG_RADIUS, 64'd0);
                    add_reg(REG_XDIR, {$urandom, $urandom});
                end
                4:
                begin
                    add_reg(REG_ORIGIN, {$urandom, $urandom});
                    add_reg(REG_XDIR, {$urandom, $urandom});
                    add_reg(REG_YDIR, {$urandom, $urandom});
                    add_reg(REG_RADIUS, {$urandom, $urandom});
                end
                default:
                begin
                    add_reg(REG_ORIGIN, 64'd0);
                    add_reg(REG_XDIR, pack_dir(16'h2D41, 16'h2D41, 16'h0000));
                    add_reg(REG_YDIR, pack_dir(16'hD2BF, 16'h2D41, 16'h0000));
                    add_reg(REG_RADIUS, 64'd1024);
                end
            endcase
            run_random(240);
            settle();
        end

        if (mismatches == 0 && expected_vec_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
